@@ sv/wes_pkg.sv @@
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types, widths, register codes and reset values for the 1-D wave
// field stencil block.
// ----------------------------------------------------------------------------
package wes_pkg;

    // grid size default for the top-level parameter
    localparam int GRID_POINTS_DEF = 64;

    // fixed field widths
    localparam int FIELD_W   = 32;   // Q15.16 pressure
    localparam int COEF_W    = 16;   // Q1.15 coefficient
    localparam int CFG_W     = 16;   // widest config register
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 6;    // point index / source position
    localparam int CNT7_W    = 7;    // points_in_use / region_split
    localparam int PEAK_W    = 31;

    // internal arithmetic widths
    localparam int LAP_W      = 35;  // r - 2c + l
    localparam int BASE_W     = 34;  // 2c - p
    localparam int MULT_W     = 52;  // lap * coef
    localparam int FRAC_SHIFT = 15;
    localparam int TERM_W     = MULT_W - FRAC_SHIFT;
    localparam int SUM_W      = 38;
    localparam int ROUND_BIAS = 16384;

    // register reset values
    localparam logic [CNT7_W-1:0] POINTS_RST = 7'd64;
    localparam logic [CNT7_W-1:0] SPLIT_RST  = 7'd48;
    localparam logic [COEF_W-1:0] COEF_L_RST = 16'd26542;
    localparam logic [COEF_W-1:0] COEF_R_RST = 16'd11796;
    localparam logic [POS_W-1:0]  SRC_RST    = 6'd20;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINTS  = 3'd0,
        CFG_SPLIT   = 3'd1,
        CFG_COEF_L  = 3'd2,
        CFG_COEF_R  = 3'd3,
        CFG_SRC_POS = 3'd4
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_seq_state;

    // per-cycle window control, aligned with the RAM read data
    typedef struct packed {
        logic load_left;   // read data is cur[n-1]
        logic load_mid;    // read data is cur[0]
        logic compute;     // a point is evaluated this cycle
        logic wrap;        // last point: right neighbor is the saved cur[0]
    } t_seq_ctl;

    // saturate a wide signed sum to the field format
    function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-FIELD_W:0] top_bits;
        logic signed [FIELD_W-1:0] res;
        top_bits = v[SUM_W-1:FIELD_W-1];
        if (top_bits == '0 || top_bits == '1) begin
            res = v[FIELD_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(FIELD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ sv/wes_ram.sv @@
// ----------------------------------------------------------------------------
// wes_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/wes_seq.sv @@
// ----------------------------------------------------------------------------
// wes_seq
// Step sequencer: walks the read addresses n-1, 0, 1, ... n-1 plus one
// wrap slot, and flags what the datapath does with each read.
// ----------------------------------------------------------------------------
module wes_seq
    import wes_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [$clog2(GRID_POINTS+2)-1:0] i_n,
    input  logic                             i_done,
    output logic                             o_busy,
    output logic                             o_accept,
    output logic [$clog2(GRID_POINTS)-1:0]   o_rd_addr,
    output t_seq_ctl                         o_ctl,
    output logic [$clog2(GRID_POINTS)-1:0]   o_pt_idx
);

    localparam int ADDR_W = $clog2(GRID_POINTS);
    localparam int CNT_W  = $clog2(GRID_POINTS + 2);

    t_seq_state        r_state, n_state;
    logic [CNT_W-1:0]  r_k, n_k;
    t_seq_ctl          r_ctl, n_ctl;
    logic [ADDR_W-1:0] r_pt_idx;
    logic              issue_end;

    assign issue_end = (r_k == i_n + CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start)   n_state = ST_ISSUE;
            ST_ISSUE: if (issue_end) n_state = ST_DRAIN;
            ST_DRAIN: if (i_done)    n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and slot counter
    always_comb begin
        o_busy    = 1'b1;
        o_accept  = 1'b0;
        o_rd_addr = ADDR_W'(r_k - CNT_W'(1));
        n_ctl     = '0;
        n_k       = r_k;
        case (r_state)
            ST_IDLE: begin
                o_busy   = 1'b0;
                o_accept = i_start;
                n_k      = '0;
            end
            ST_ISSUE: begin
                if (r_k == '0) begin
                    o_rd_addr = ADDR_W'(i_n - CNT_W'(1));
                end
                n_ctl.load_left = (r_k == CNT_W'(0));
                n_ctl.load_mid  = (r_k == CNT_W'(1));
                n_ctl.compute   = (r_k >= CNT_W'(2));
                n_ctl.wrap      = issue_end;
                n_k             = r_k + CNT_W'(1);
            end
            ST_DRAIN: begin
                n_k = '0;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    // state registers; control flags line up with the RAM read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_ctl   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ctl   <= n_ctl;
        end
        r_pt_idx <= ADDR_W'(r_k - CNT_W'(2));
    end

    assign o_ctl    = r_ctl;
    assign o_pt_idx = r_pt_idx;

endmodule

@@ sv/wes_dp.sv @@
// ----------------------------------------------------------------------------
// wes_dp
// Stencil datapath: three-point window, laplacian, coefficient multiply,
// rounding, leapfrog sum, saturation, source injection and peak tracking.
// ----------------------------------------------------------------------------
module wes_dp
    import wes_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic signed [FIELD_W-1:0]      i_source_sample,
    input  logic [CNT7_W-1:0]              i_split,
    input  logic [COEF_W-1:0]              i_coef_l,
    input  logic [COEF_W-1:0]              i_coef_r,
    input  logic [POS_W-1:0]               i_src_pos,
    input  t_seq_ctl                       i_ctl,
    input  logic [$clog2(GRID_POINTS)-1:0] i_pt_idx,
    input  logic signed [FIELD_W-1:0]      i_cur,
    input  logic signed [FIELD_W-1:0]      i_prev,
    output logic                           o_we,
    output logic [$clog2(GRID_POINTS)-1:0] o_waddr,
    output logic [FIELD_W-1:0]             o_wdata,
    output logic                           o_valid,
    output logic [POS_W-1:0]               o_point_index,
    output logic signed [FIELD_W-1:0]      o_pressure,
    output logic [PEAK_W-1:0]              o_field_peak,
    output logic                           o_last
);

    localparam int ADDR_W = $clog2(GRID_POINTS);

    // source sample and peak for the step in progress
    logic signed [FIELD_W-1:0] r_src;
    logic signed [FIELD_W-1:0] r_peak;

    // window
    logic signed [FIELD_W-1:0] r_left, r_mid, r_c0, r_pmid;

    // stage A
    logic                      r_a_vld, r_a_last;
    logic signed [LAP_W-1:0]   r_a_lap;
    logic signed [BASE_W-1:0]  r_a_base;
    logic [COEF_W-1:0]         r_a_coef;
    logic signed [FIELD_W-1:0] r_a_cur;
    logic [ADDR_W-1:0]         r_a_idx;

    // stage B
    logic                      r_b_vld, r_b_last;
    logic signed [MULT_W-1:0]  r_b_prod;
    logic signed [BASE_W-1:0]  r_b_base;
    logic signed [FIELD_W-1:0] r_b_cur;
    logic [ADDR_W-1:0]         r_b_idx;

    // output register
    logic                      r_out_valid, r_out_last;
    logic [POS_W-1:0]          r_out_idx;
    logic signed [FIELD_W-1:0] r_out_press;
    logic [PEAK_W-1:0]         r_out_peak;

    logic signed [FIELD_W-1:0] right;
    logic signed [LAP_W-1:0]   lap;
    logic signed [BASE_W-1:0]  base;
    logic signed [MULT_W-1:0]  rounded;
    logic signed [TERM_W-1:0]  term;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   inj;
    logic signed [FIELD_W-1:0] v_new, v_out, peak_nxt;

    // window arithmetic
    always_comb begin
        right = i_ctl.wrap ? r_c0 : i_cur;
        lap   = LAP_W'(right) - (LAP_W'(r_mid) <<< 1) + LAP_W'(r_left);
        base  = (BASE_W'(r_mid) <<< 1) - BASE_W'(r_pmid);
    end

    // round, leapfrog sum, saturate, inject
    always_comb begin
        rounded  = r_b_prod + MULT_W'(ROUND_BIAS);
        term     = $signed(rounded[MULT_W-1:FRAC_SHIFT]);
        sum      = SUM_W'(r_b_base) + SUM_W'(term);
        v_new    = sat_field(sum);
        inj      = SUM_W'(v_new) + SUM_W'(r_src);
        v_out    = (POS_W'(r_b_idx) == i_src_pos) ? sat_field(inj) : v_new;
        peak_nxt = (v_new > r_peak) ? v_new : r_peak;
    end

    // control of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_vld     <= i_ctl.compute;
            r_b_vld     <= r_a_vld;
            r_out_valid <= r_b_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_src  <= i_source_sample;
            r_peak <= '0;
        end else if (r_b_vld) begin
            r_peak <= peak_nxt;
        end

        if (i_ctl.load_left) begin
            r_left <= i_cur;
        end
        if (i_ctl.load_mid) begin
            r_mid  <= i_cur;
            r_c0   <= i_cur;
            r_pmid <= i_prev;
        end
        if (i_ctl.compute) begin
            r_left <= r_mid;
            r_mid  <= i_cur;
            r_pmid <= i_prev;
        end

        // stage A
        r_a_lap  <= lap;
        r_a_base <= base;
        r_a_coef <= (CNT7_W'(i_pt_idx) < i_split) ? i_coef_l : i_coef_r;
        r_a_cur  <= r_mid;
        r_a_idx  <= i_pt_idx;
        r_a_last <= i_ctl.wrap;

        // stage B: coefficient multiply
        r_b_prod <= r_a_lap * $signed({1'b0, r_a_coef});
        r_b_base <= r_a_base;
        r_b_cur  <= r_a_cur;
        r_b_idx  <= r_a_idx;
        r_b_last <= r_a_last;

        // result register
        r_out_idx   <= POS_W'(r_b_idx);
        r_out_press <= r_b_cur;
        r_out_last  <= r_b_last;
        r_out_peak  <= r_b_last ? peak_nxt[PEAK_W-1:0] : '0;
    end

    assign o_we          = r_b_vld;
    assign o_waddr       = r_b_idx;
    assign o_wdata       = v_out;
    assign o_valid       = r_out_valid;
    assign o_point_index = r_out_idx;
    assign o_pressure    = r_out_press;
    assign o_field_peak  = r_out_peak;
    assign o_last        = r_out_last;

endmodule

@@ sv/wave_equation_stencil_step_top.sv @@
// ----------------------------------------------------------------------------
// wave_equation_stencil_step_top
// One leapfrog time step of a cyclic 1-D acoustic wave field per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken at a rising edge with start high and busy
//   low; it carries the source sample for one time step.
//   Output: one result per grid point in use, in index order, each shown for
//   one cycle with o_valid high. o_last marks the final point, and there
//   o_field_peak holds the peak of the new field (floored at zero, before the
//   source is added). The receiver cannot stall; results are never held.
//   Pipeline: RAM read register, stage A, stage B, result register.
//   Step: a new transaction is taken only once busy falls after the last
//   result (n = points in use); each step makes n + 2 reads (left neighbor,
//   points 0..n-1, wrap slot) on the single read port of each field RAM,
//   then drains the arithmetic pipeline and returns to idle.
//   Config: plain write port, taken at any edge with i_cfg_we high; write
//   only while busy is low.
//   Reset: synchronous, active low. Both fields read as zero afterwards
//   through per-entry valid flags; no clearing pass is needed.
//   The two field RAMs swap roles per entry: a select flag per point tells
//   which RAM holds the current value, and the new value overwrites the old.
// ----------------------------------------------------------------------------
module wave_equation_stencil_step_top
    import wes_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [FIELD_W-1:0] i_source_sample,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output logic                      o_valid,
    output logic [POS_W-1:0]          o_point_index,
    output logic signed [FIELD_W-1:0] o_pressure,
    output logic [PEAK_W-1:0]         o_field_peak,
    output logic                      o_last
);

    localparam int ADDR_W = $clog2(GRID_POINTS);
    localparam int CNT_W  = $clog2(GRID_POINTS + 2);
    localparam logic [CNT7_W-1:0] GRID_MAX = CNT7_W'(GRID_POINTS);
    localparam logic [CNT7_W-1:0] GRID_MIN = CNT7_W'(3);

    // configuration registers
    logic [CNT7_W-1:0] r_points, r_split;
    logic [COEF_W-1:0] r_coef_l, r_coef_r;
    logic [POS_W-1:0]  r_src_pos;
    logic [CNT7_W-1:0] pts_clamped;
    logic [CNT_W-1:0]  n_eff;

    // per-entry bank select and valid flags
    logic [GRID_POINTS-1:0] r_sel, r_vld_a, r_vld_b;
    logic                   r_rd_sel, r_rd_va, r_rd_vb;

    logic                      accept, done;
    logic [ADDR_W-1:0]         rd_addr, pt_idx, waddr;
    t_seq_ctl                  ctl;
    logic                      we, we_a, we_b;
    logic [FIELD_W-1:0]        wdata, q_a, q_b, a_val, b_val;
    logic signed [FIELD_W-1:0] cur_val, prev_val;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points  <= POINTS_RST;
            r_split   <= SPLIT_RST;
            r_coef_l  <= COEF_L_RST;
            r_coef_r  <= COEF_R_RST;
            r_src_pos <= SRC_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POINTS:  r_points  <= i_cfg_data[CNT7_W-1:0];
                CFG_SPLIT:   r_split   <= i_cfg_data[CNT7_W-1:0];
                CFG_COEF_L:  r_coef_l  <= i_cfg_data;
                CFG_COEF_R:  r_coef_r  <= i_cfg_data;
                CFG_SRC_POS: r_src_pos <= i_cfg_data[POS_W-1:0];
                default:     ;
            endcase
        end
    end

    // points in use, clamped to the grid
    always_comb begin
        if (r_points < GRID_MIN) begin
            pts_clamped = GRID_MIN;
        end else if (r_points > GRID_MAX) begin
            pts_clamped = GRID_MAX;
        end else begin
            pts_clamped = r_points;
        end
        n_eff = CNT_W'(pts_clamped);
    end

    // sequencer
    wes_seq #(
        .GRID_POINTS (GRID_POINTS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_n       (n_eff),
        .i_done    (done),
        .o_busy    (busy),
        .o_accept  (accept),
        .o_rd_addr (rd_addr),
        .o_ctl     (ctl),
        .o_pt_idx  (pt_idx)
    );

    // new value goes to the bank that holds the previous value
    assign we_a = we &  r_sel[waddr];
    assign we_b = we & ~r_sel[waddr];

    wes_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (GRID_POINTS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (q_a)
    );

    wes_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (GRID_POINTS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (q_b)
    );

    // flags: swap on write, capture alongside the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= '0;
            r_vld_a <= '0;
            r_vld_b <= '0;
        end else if (we) begin
            r_sel[waddr] <= ~r_sel[waddr];
            if (r_sel[waddr]) begin
                r_vld_a[waddr] <= 1'b1;
            end else begin
                r_vld_b[waddr] <= 1'b1;
            end
        end
        r_rd_sel <= r_sel[rd_addr];
        r_rd_va  <= r_vld_a[rd_addr];
        r_rd_vb  <= r_vld_b[rd_addr];
    end

    // unwritten entries read as zero; select picks current vs previous
    always_comb begin
        a_val    = r_rd_va ? q_a : '0;
        b_val    = r_rd_vb ? q_b : '0;
        cur_val  = r_rd_sel ? b_val : a_val;
        prev_val = r_rd_sel ? a_val : b_val;
    end

    // stencil datapath
    wes_dp #(
        .GRID_POINTS (GRID_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_source_sample (i_source_sample),
        .i_split         (r_split),
        .i_coef_l        (r_coef_l),
        .i_coef_r        (r_coef_r),
        .i_src_pos       (r_src_pos),
        .i_ctl           (ctl),
        .i_pt_idx        (pt_idx),
        .i_cur           (cur_val),
        .i_prev          (prev_val),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_valid         (o_valid),
        .o_point_index   (o_point_index),
        .o_pressure      (o_pressure),
        .o_field_peak    (o_field_peak),
        .o_last          (o_last)
    );

    // step ends with the last result on the ports
    assign done = o_valid & o_last;

endmodule
